>>> hw/rtl/tbpr_pkg.sv
// tbpr_pkg: shared types and constants of the background tile renderer
// used by every module under hw/rtl but tbpr_fifo; depends on nothing
`timescale 1ns / 1ps

package tbpr_pkg;

  // video memory geometry: two byte banks, even and odd addresses
  localparam int unsigned VMEM_AW    = 13;
  localparam int unsigned VMEM_DEPTH = 1 << VMEM_AW;
  localparam int unsigned NUM_BANKS  = 2;
  localparam int unsigned BANK_AW    = VMEM_AW - 1;
  localparam int unsigned BANK_DEPTH = VMEM_DEPTH / NUM_BANKS;

  // tile map layout
  localparam int unsigned MAP_WIDTH_TILES = 32;
  localparam int unsigned MAP_SHIFT       = $clog2(MAP_WIDTH_TILES);
  localparam logic [VMEM_AW-1:0] MAP_BASE_0 = 13'h1800;
  localparam logic [VMEM_AW-1:0] MAP_BASE_1 = 13'h1C00;

  // signed tile set: indices below the limit move up by the offset
  localparam logic [7:0] TILE_LOW_LIMIT   = 8'd128;
  localparam logic [8:0] TILE_SET_OFFSET  = 9'd256;

  // defaults of the top level parameters
  localparam int unsigned SCREEN_WIDTH_DEFAULT = 160;
  localparam int unsigned CMD_DEPTH_DEFAULT    = 2;
  localparam int unsigned RES_DEPTH_DEFAULT    = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HSCROLL         = 4'd0,
    CFG_VSCROLL         = 4'd1,
    CFG_MAP_SELECT      = 4'd2,
    CFG_TILE_SET_SELECT = 4'd3,
    CFG_PALETTE_0       = 4'd4,
    CFG_PALETTE_1       = 4'd5,
    CFG_PALETTE_2       = 4'd6,
    CFG_PALETTE_3       = 4'd7
  } cfg_idx_e;

  localparam logic [23:0] PALETTE_0_RESET = 24'hFFFFFF;
  localparam logic [23:0] PALETTE_1_RESET = 24'hC0C0C0;
  localparam logic [23:0] PALETTE_2_RESET = 24'h606060;
  localparam logic [23:0] PALETTE_3_RESET = 24'h000000;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [VMEM_AW-1:0] mem_addr;
    logic [7:0]         mem_data;
    logic [7:0]         screen_line;
    logic [7:0]         screen_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] shade;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       h_scroll;
    logic [7:0]       v_scroll;
    logic             map_select;
    logic             tile_set_select;
    logic [3:0][23:0] palette;
  } cfg_t;

  // work handed from front to back: a byte write or a map lookup
  typedef struct packed {
    op_e                op;
    logic [VMEM_AW-1:0] addr;
    logic [7:0]         data;
    logic [2:0]         fine_y;
    logic [2:0]         fine_x;
  } cmd_t;

endpackage

>>> hw/rtl/tbpr_fifo.sv
// tbpr_fifo: small register queue of any payload type
// depends on nothing but its parameters
`timescale 1ns / 1ps

module tbpr_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  T                           data_i,
  input  logic                       pop_i,
  output T                           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  T                entries_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/tbpr_front.sv
// tbpr_front: takes input items, drops off-screen pixels, computes map address
// depends on tbpr_pkg and tbpr_fifo
`timescale 1ns / 1ps

module tbpr_front #(
  parameter int unsigned SCREEN_WIDTH = tbpr_pkg::SCREEN_WIDTH_DEFAULT,
  parameter int unsigned CMD_DEPTH    = tbpr_pkg::CMD_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tbpr_pkg::in_item_t in_i,
  input  logic               busy_i,
  input  tbpr_pkg::cfg_t     cfg_i,
  output logic               full_o,
  output logic               cmd_valid_o,
  output tbpr_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);

  logic                         accept;
  logic                         on_screen;
  logic                         enqueue;
  logic [7:0]                   bg_x, bg_y;
  logic [tbpr_pkg::VMEM_AW-1:0] map_ptr;
  tbpr_pkg::cmd_t               cmd;
  logic                         q_full, q_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] q_count;

  assign full_o    = busy_i || q_full;
  assign accept    = push_i && !full_o;
  assign on_screen = ({1'b0, in_i.screen_col} < 9'(SCREEN_WIDTH));
  assign enqueue   = accept && ((in_i.op == tbpr_pkg::OP_WRITE) || on_screen);

  assign bg_y = in_i.screen_line + cfg_i.v_scroll;
  assign bg_x = in_i.screen_col + cfg_i.h_scroll;

  always_comb begin
    map_ptr = cfg_i.map_select ? tbpr_pkg::MAP_BASE_1 : tbpr_pkg::MAP_BASE_0;
    map_ptr = map_ptr
            + (tbpr_pkg::VMEM_AW'(bg_y[7:3]) << tbpr_pkg::MAP_SHIFT)
            + tbpr_pkg::VMEM_AW'(bg_x[7:3]);
  end

  always_comb begin
    cmd.op     = in_i.op;
    cmd.addr   = (in_i.op == tbpr_pkg::OP_WRITE) ? in_i.mem_addr : map_ptr;
    cmd.data   = in_i.mem_data;
    cmd.fine_y = bg_y[2:0];
    cmd.fine_x = bg_x[2:0];
  end

  tbpr_fifo #(
    .T     (tbpr_pkg::cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enqueue),
    .data_i  (cmd),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  // the count test is redundant with the empty flag here
  assign cmd_valid_o = !q_empty && (q_count != '0);

endmodule

>>> hw/rtl/tbpr_back.sv
// tbpr_back: video memory banks, clearing pass, map and tile read pipeline
// depends on tbpr_pkg and tbpr_fifo
`timescale 1ns / 1ps

module tbpr_back #(
  parameter int unsigned RES_DEPTH = tbpr_pkg::RES_DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  tbpr_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  tbpr_pkg::cfg_t      cfg_i,
  output logic                busy_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tbpr_pkg::out_item_t out_o
);

  localparam int unsigned BAW = tbpr_pkg::BANK_AW;
  localparam int unsigned NB  = tbpr_pkg::NUM_BANKS;
  localparam int unsigned CW  = $clog2(RES_DEPTH+1);

  // two byte banks: even addresses in bank 0, odd in bank 1
  logic [7:0]     bank_q [NB][tbpr_pkg::BANK_DEPTH];
  logic [7:0]     rd_a_q [NB];
  logic [7:0]     rd_b_q [NB];

  logic [BAW:0]   clr_cnt_q, clr_cnt_d;
  logic           clearing;

  logic           issue, issue_render;
  logic [NB-1:0]  wr_en;
  logic [BAW-1:0] wr_idx;
  logic [7:0]     wr_data;
  logic [BAW-1:0] rd_a_idx, rd_b_idx;

  logic           s1_valid_q, s2_valid_q;
  logic           s1_sel_q;
  logic [2:0]     s1_fy_q, s1_fx_q, s2_fx_q;

  logic [7:0]     map_byte;
  logic [8:0]     tile;
  logic [tbpr_pkg::VMEM_AW-1:0] row_addr;
  logic [2:0]     bit_sel;
  logic [1:0]     shade;
  logic [23:0]    colour;
  tbpr_pkg::out_item_t res;

  logic           res_full;
  logic [CW-1:0]  res_count;
  logic [CW:0]    pending;

  assign clearing = !clr_cnt_q[BAW];
  assign busy_o   = clearing;
  assign clr_cnt_d = clearing ? clr_cnt_q + 1'b1 : clr_cnt_q;

  // results already queued or still in the pipe must all fit
  assign pending = (CW+1)'(res_count) + (CW+1)'(s1_valid_q) + (CW+1)'(s2_valid_q);
  assign issue = cmd_valid_i && !clearing
              && ((cmd_i.op == tbpr_pkg::OP_WRITE) || (pending < (CW+1)'(RES_DEPTH)));
  assign issue_render = issue && (cmd_i.op == tbpr_pkg::OP_RENDER);
  assign cmd_pop_o = issue;

  always_comb begin
    wr_en   = '0;
    wr_idx  = cmd_i.addr[tbpr_pkg::VMEM_AW-1:1];
    wr_data = cmd_i.data;
    if (clearing) begin
      wr_en   = '1;
      wr_idx  = clr_cnt_q[BAW-1:0];
      wr_data = '0;
    end else if (issue && (cmd_i.op == tbpr_pkg::OP_WRITE)) begin
      wr_en[cmd_i.addr[0]] = 1'b1;
    end
  end

  assign rd_a_idx = cmd_i.addr[tbpr_pkg::VMEM_AW-1:1];

  // stage 1: map byte is back, resolve the tile and its row address
  always_comb begin
    map_byte = rd_a_q[s1_sel_q];
    if (cfg_i.tile_set_select && (map_byte < tbpr_pkg::TILE_LOW_LIMIT)) begin
      tile = {1'b0, map_byte} + tbpr_pkg::TILE_SET_OFFSET;
    end else begin
      tile = {1'b0, map_byte};
    end
    row_addr = {tile, s1_fy_q, 1'b0};
  end

  assign rd_b_idx = row_addr[tbpr_pkg::VMEM_AW-1:1];

  // stage 2: both bit planes are back, pick the pixel and its colour
  always_comb begin
    bit_sel   = 3'd7 - s2_fx_q;
    shade     = {rd_b_q[1][bit_sel], rd_b_q[0][bit_sel]};
    colour    = cfg_i.palette[shade];
    res.red   = colour[23:16];
    res.green = colour[15:8];
    res.blue  = colour[7:0];
    res.shade = shade;
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NB; b++) begin
      if (wr_en[b]) begin
        bank_q[b][wr_idx] <= wr_data;
      end
      rd_a_q[b] <= bank_q[b][rd_a_idx];
      rd_b_q[b] <= bank_q[b][rd_b_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      s1_valid_q <= issue_render;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sel_q <= cmd_i.addr[0];
    s1_fy_q  <= cmd_i.fine_y;
    s1_fx_q  <= cmd_i.fine_x;
    s2_fx_q  <= s1_fx_q;
  end

  tbpr_fifo #(
    .T     (tbpr_pkg::out_item_t),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q && !res_full),
    .data_i  (res),
    .pop_i   (pop_i),
    .data_o  (out_o),
    .full_o  (res_full),
    .empty_o (empty_o),
    .count_o (res_count)
  );

endmodule

>>> hw/rtl/tile_background_pixel_renderer_core.sv
// background tile renderer: one result per on-screen pixel item, via command queue,
// stage 1, stage 2 and result queue; one item per cycle sustained while results are
// popped and no clearing runs, set by the dependent map byte and tile row reads being
// pipelined. reset: config registers take reset values, a clearing pass zeroes the
// 8 KiB video memory with full held high; config writes are taken always
`timescale 1ns / 1ps

module tile_background_pixel_renderer_core #(
  parameter int unsigned SCREEN_WIDTH = tbpr_pkg::SCREEN_WIDTH_DEFAULT,
  parameter int unsigned CMD_DEPTH    = tbpr_pkg::CMD_DEPTH_DEFAULT,
  parameter int unsigned RES_DEPTH    = tbpr_pkg::RES_DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input queue side
  input  logic                              push,
  output logic                              full,
  input  tbpr_pkg::in_item_t                in_i,
  // result queue side
  output logic                              empty,
  input  logic                              pop,
  output tbpr_pkg::out_item_t               out_o,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tbpr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tbpr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  tbpr_pkg::cfg_t cfg_q, cfg_d;
  tbpr_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;
  logic           busy;

  // the user must write registers only while idle (unchecked), so no handshake stall
  assign cfg_ready = 1'b1;

  // register file: unknown indices fall through and leave everything as is
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid && cfg_ready) begin
      case (tbpr_pkg::cfg_idx_e'(cfg_index_i))
        tbpr_pkg::CFG_HSCROLL:         cfg_d.h_scroll        = cfg_data_i[7:0];
        tbpr_pkg::CFG_VSCROLL:         cfg_d.v_scroll        = cfg_data_i[7:0];
        tbpr_pkg::CFG_MAP_SELECT:      cfg_d.map_select      = cfg_data_i[0];
        tbpr_pkg::CFG_TILE_SET_SELECT: cfg_d.tile_set_select = cfg_data_i[0];
        tbpr_pkg::CFG_PALETTE_0:       cfg_d.palette[0]      = cfg_data_i[23:0];
        tbpr_pkg::CFG_PALETTE_1:       cfg_d.palette[1]      = cfg_data_i[23:0];
        tbpr_pkg::CFG_PALETTE_2:       cfg_d.palette[2]      = cfg_data_i[23:0];
        tbpr_pkg::CFG_PALETTE_3:       cfg_d.palette[3]      = cfg_data_i[23:0];
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h_scroll        <= '0;
      cfg_q.v_scroll        <= '0;
      cfg_q.map_select      <= 1'b0;
      cfg_q.tile_set_select <= 1'b0;
      cfg_q.palette[0]      <= tbpr_pkg::PALETTE_0_RESET;
      cfg_q.palette[1]      <= tbpr_pkg::PALETTE_1_RESET;
      cfg_q.palette[2]      <= tbpr_pkg::PALETTE_2_RESET;
      cfg_q.palette[3]      <= tbpr_pkg::PALETTE_3_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classifies each transfer, drops off-screen columns, queues the rest
  // with the scrolled map address already worked out
  tbpr_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .CMD_DEPTH    (CMD_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_i        (in_i),
    .busy_i      (busy),
    .cfg_i       (cfg_q),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: byte writes and renders run in queue order through the memory;
  // a render reads the map byte, then both tile planes, then looks up the palette.
  // it only issues a render when the result queue has room for everything in flight
  tbpr_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .busy_o      (busy),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (out_o)
  );

endmodule
